// File: sv/vrq_pkg.sv
package vrq_pkg;

   // Field widths
   localparam int DATA_W = 16;

   // Default fraction bits of the quaternion components (Q1.14)
   localparam int QUAT_FRAC_BITS_DEF = 14;

   // Arithmetic widths through the pipeline
   localparam int P1_W = 2 * DATA_W;       // v * q products
   localparam int T_W  = P1_W + 1;         // three-term sums of q * (0, v)
   localparam int P2_W = T_W + DATA_W;     // t * q products
   localparam int U_W  = P2_W + 2;         // four-term sums of t * conj(q)

   // Pipeline depth
   localparam int NUM_STG = 5;

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [P1_W-1:0]   prod1_type;
   typedef logic signed [T_W-1:0]    tsum_type;
   typedef logic signed [P2_W-1:0]   prod2_type;
   typedef logic signed [U_W-1:0]    usum_type;

   typedef struct packed {
      data_type w;
      data_type x;
      data_type y;
      data_type z;
   } quat_type;

endpackage

// File: sv/vrq_if.sv
interface vrq_req_if
   import vrq_pkg::*;
   ();
   logic     valid;
   logic     ready;
   data_type vec_x;
   data_type vec_y;
   data_type vec_z;
   data_type quat_w;
   data_type quat_x;
   data_type quat_y;
   data_type quat_z;

   modport source (
      output valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
      input  ready
   );
   modport sink (
      input  valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
      output ready
   );
endinterface

interface vrq_rsp_if
   import vrq_pkg::*;
   ();
   logic     valid;
   logic     ready;
   data_type rot_x;
   data_type rot_y;
   data_type rot_z;
   logic     clipped;

   modport source (
      output valid, rot_x, rot_y, rot_z, clipped,
      input  ready
   );
   modport sink (
      input  valid, rot_x, rot_y, rot_z, clipped,
      output ready
   );
endinterface

// File: sv/vector_rotate_by_quaternion.sv
// Rotates a signed 16-bit 3-vector by a Q1.14 orientation quaternion: q * (0,v) * conj(q).
//
// Channels: req (sink) carries vec_x/y/z and quat_w/x/y/z; rsp (source) carries
// rot_x/y/z and clipped. A transaction moves at a clock edge with valid and ready high.
// The quaternion is used as given; an unnormalized one scales the result by |q|^2.
// Each component is divided by 2^(2*QUAT_FRAC_BITS) truncating toward zero and
// saturated to 16 bits; clipped is set when any component saturates.
//
// Pipeline: five register stages (v*q products, q*(0,v) sums, t*q products,
// t*conj(q) sums, scale/saturate), the first loading at the request's accepting edge
// and the last driving rsp valid and the result.
// Throughput: one transaction per cycle while rsp is not stalled.
// Stall: each stage holds while the stage after it is full and not moving, so a
// stalled rsp keeps its payload stable and the request side keeps accepting until
// all five stages are full; bubbles are squeezed out.
// Reset (synchronous, active high) empties the pipeline; no data is lost or repeated
// outside of reset.
module vector_rotate_by_quaternion
   import vrq_pkg::*;
#(
   parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   vrq_req_if.sink   req,
   vrq_rsp_if.source rsp
);

   localparam int SHIFT = 2 * QUAT_FRAC_BITS;
   localparam int Q_W   = U_W - SHIFT;

   // Stage valid bits and advance enables
   logic [NUM_STG-1:0] vld_ff;
   logic [NUM_STG-1:0] vld_in;
   logic [NUM_STG-1:0] adv;

   always_comb begin
      adv[NUM_STG-1] = !vld_ff[NUM_STG-1] || rsp.ready;
      for (int i = NUM_STG - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = req.valid;
      for (int i = 1; i < NUM_STG; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STG; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req.ready = adv[0];

   // Stage 1: products of q and v
   prod1_type p1_ff [12];
   prod1_type p1_in [12];
   quat_type  q1_ff;

   always_comb begin
      p1_in[0]  = P1_W'(req.quat_x) * P1_W'(req.vec_x);
      p1_in[1]  = P1_W'(req.quat_y) * P1_W'(req.vec_y);
      p1_in[2]  = P1_W'(req.quat_z) * P1_W'(req.vec_z);
      p1_in[3]  = P1_W'(req.quat_w) * P1_W'(req.vec_x);
      p1_in[4]  = P1_W'(req.quat_y) * P1_W'(req.vec_z);
      p1_in[5]  = P1_W'(req.quat_z) * P1_W'(req.vec_y);
      p1_in[6]  = P1_W'(req.quat_w) * P1_W'(req.vec_y);
      p1_in[7]  = P1_W'(req.quat_x) * P1_W'(req.vec_z);
      p1_in[8]  = P1_W'(req.quat_z) * P1_W'(req.vec_x);
      p1_in[9]  = P1_W'(req.quat_w) * P1_W'(req.vec_z);
      p1_in[10] = P1_W'(req.quat_x) * P1_W'(req.vec_y);
      p1_in[11] = P1_W'(req.quat_y) * P1_W'(req.vec_x);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         p1_ff <= p1_in;
         q1_ff <= '{w: req.quat_w, x: req.quat_x, y: req.quat_y, z: req.quat_z};
      end
   end

   // Stage 2: t = q * (0, v)
   tsum_type t_ff [4];
   tsum_type t_in [4];
   quat_type q2_ff;

   always_comb begin
      t_in[0] = -T_W'(p1_ff[0]) - T_W'(p1_ff[1]) - T_W'(p1_ff[2]);
      t_in[1] =  T_W'(p1_ff[3]) + T_W'(p1_ff[4]) - T_W'(p1_ff[5]);
      t_in[2] =  T_W'(p1_ff[6]) - T_W'(p1_ff[7]) + T_W'(p1_ff[8]);
      t_in[3] =  T_W'(p1_ff[9]) + T_W'(p1_ff[10]) - T_W'(p1_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         t_ff  <= t_in;
         q2_ff <= q1_ff;
      end
   end

   // Stage 3: products of t and q for t * conj(q)
   prod2_type p2_ff [12];
   prod2_type p2_in [12];

   always_comb begin
      // x: -tw*qx + tx*qw - ty*qz + tz*qy
      p2_in[0]  = P2_W'(t_ff[0]) * P2_W'(q2_ff.x);
      p2_in[1]  = P2_W'(t_ff[1]) * P2_W'(q2_ff.w);
      p2_in[2]  = P2_W'(t_ff[2]) * P2_W'(q2_ff.z);
      p2_in[3]  = P2_W'(t_ff[3]) * P2_W'(q2_ff.y);
      // y: -tw*qy + tx*qz + ty*qw - tz*qx
      p2_in[4]  = P2_W'(t_ff[0]) * P2_W'(q2_ff.y);
      p2_in[5]  = P2_W'(t_ff[1]) * P2_W'(q2_ff.z);
      p2_in[6]  = P2_W'(t_ff[2]) * P2_W'(q2_ff.w);
      p2_in[7]  = P2_W'(t_ff[3]) * P2_W'(q2_ff.x);
      // z: -tw*qz - tx*qy + ty*qx + tz*qw
      p2_in[8]  = P2_W'(t_ff[0]) * P2_W'(q2_ff.z);
      p2_in[9]  = P2_W'(t_ff[1]) * P2_W'(q2_ff.y);
      p2_in[10] = P2_W'(t_ff[2]) * P2_W'(q2_ff.x);
      p2_in[11] = P2_W'(t_ff[3]) * P2_W'(q2_ff.w);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         p2_ff <= p2_in;
      end
   end

   // Stage 4: vector part of t * conj(q)
   usum_type u_ff [3];
   usum_type u_in [3];

   always_comb begin
      u_in[0] = -U_W'(p2_ff[0]) + U_W'(p2_ff[1]) - U_W'(p2_ff[2])  + U_W'(p2_ff[3]);
      u_in[1] = -U_W'(p2_ff[4]) + U_W'(p2_ff[5]) + U_W'(p2_ff[6])  - U_W'(p2_ff[7]);
      u_in[2] = -U_W'(p2_ff[8]) - U_W'(p2_ff[9]) + U_W'(p2_ff[10]) + U_W'(p2_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         u_ff <= u_in;
      end
   end

   // Stage 5: scale toward zero, saturate, flag clipping
   data_type rot_ff [3];
   data_type rot_in [3];
   logic     clip_ff;
   logic     clip_in;

   always_comb begin
      logic signed [Q_W-1:0] quot;
      logic                  frac_nz;
      clip_in = 1'b0;
      for (int c = 0; c < 3; c++) begin
         frac_nz = |u_ff[c][SHIFT-1:0];
         quot    = Q_W'(u_ff[c] >>> SHIFT) + Q_W'(u_ff[c][U_W-1] && frac_nz);
         if (quot > Q_W'(SAT_MAX)) begin
            rot_in[c] = SAT_MAX;
            clip_in   = 1'b1;
         end else if (quot < Q_W'(SAT_MIN)) begin
            rot_in[c] = SAT_MIN;
            clip_in   = 1'b1;
         end else begin
            rot_in[c] = quot[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         rot_ff  <= rot_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp.valid   = vld_ff[NUM_STG-1];
   assign rsp.rot_x   = rot_ff[0];
   assign rsp.rot_y   = rot_ff[1];
   assign rsp.rot_z   = rot_ff[2];
   assign rsp.clipped = clip_ff;

   // A flagged result has at least one component on a rail
   a_clip_on_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.clipped) |->
         (rsp.rot_x == SAT_MAX || rsp.rot_x == SAT_MIN ||
          rsp.rot_y == SAT_MAX || rsp.rot_y == SAT_MIN ||
          rsp.rot_z == SAT_MAX || rsp.rot_z == SAT_MIN))
      else $error("clipped set with no saturated component");

   // A stage that is full and blocked stays full
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((vld_ff & $past(vld_ff & ~adv)) == $past(vld_ff & ~adv)))
      else $error("pipeline stage lost its transaction while blocked");

   // Blocked output stage keeps its result
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=>
         (rsp.valid && $stable(rot_ff[0]) && $stable(rot_ff[1]) &&
          $stable(rot_ff[2]) && $stable(clip_ff)))
      else $error("stalled result changed");

   // Requests are only refused when every stage is occupied
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (&vld_ff && !rsp.ready))
      else $error("request refused with room in the pipeline");

endmodule

// File: tb/sv/vector_rotate_by_quaternion_test.sv
module vector_rotate_by_quaternion_test;
   import vrq_pkg::*;

   localparam int ROT_ITEMS       = 1500;
   localparam int IDLE_LIMIT      = 2000;
   localparam int HOLD_OFF_AT     = 200;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int MAX_IDLE        = 10;
   localparam int STRETCH_LEN     = 100;

   // how a directed row is checked
   localparam int BY_MODEL = 0;
   localparam int TYPED    = 1;

   localparam int NUM_ROWS = 17;
   localparam int ROW_COLS = 12;

   typedef struct {
      data_type vec_x;
      data_type vec_y;
      data_type vec_z;
      quat_type quat;
   } rotation_req_type;

   typedef struct {
      data_type rot_x;
      data_type rot_y;
      data_type rot_z;
      logic     clipped;
   } rotated_vec_type;

   logic clock = 1'b0;
   logic reset;

   vrq_req_if req_if ();
   vrq_rsp_if rsp_if ();

   vector_rotate_by_quaternion i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always #4 clock = ~clock;

   // rotated vectors still owed by the block, oldest first
   rotated_vec_type rotated_q[$];
   int error_count = 0;
   int idle_cycles = 0;
   int rsp_count   = 0;
   bit send_calm   = 1'b0;
   bit recv_calm   = 1'b0;
   bit held_off    = 1'b0;

   // vx, vy, vz, qw, qx, qy, qz, check, rx, ry, rz, clipped
   int dir_rows [NUM_ROWS][ROW_COLS] = '{
      // identity and its negative leave the vector alone
      '{ 32767, -32768,      0,  16384,      0,      0,      0, TYPED,
         32767, -32768,      0, 0},
      '{-32768,  32767,      1, -16384,      0,      0,      0, TYPED,
        -32768,  32767,      1, 0},
      '{    -1,      1,     -1,  16384,      0,      0,      0, TYPED,
            -1,      1,     -1, 0},
      // zero quaternion, zero vector
      '{ 32767,  32767, -32768,      0,      0,      0,      0, TYPED,
             0,      0,      0, 0},
      '{     0,      0,      0,  32767,  32767,  32767,  32767, TYPED,
             0,      0,      0, 0},
      // |q|^2 = 16: every component saturates
      '{ 32767,  32767,  32767, -32768, -32768, -32768, -32768, TYPED,
         int'(SAT_MAX), int'(SAT_MAX), int'(SAT_MAX), 1},
      '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, TYPED,
         int'(SAT_MIN), int'(SAT_MIN), int'(SAT_MIN), 1},
      // unit quaternion about (1,1,1): equal components stay put
      '{ 32767,  32767,  32767,   8192,   8192,   8192,   8192, TYPED,
         32767,  32767,  32767, 0},
      // tiny quaternion: truncation toward zero on both signs
      '{ 32767, -32767,      1,      1,      0,      0,      0, TYPED,
             0,      0,      0, 0},
      // |q|^2 = 4: two components clip, one does not
      '{ 16384, -16385,   8191, -32768,      0,      0,      0, TYPED,
         int'(SAT_MAX), int'(SAT_MIN), 32764, 1},
      // negative quotient just short of an integer
      '{-32768, -32768, -32768,  16383,      0,      0,      0, BY_MODEL,
             0,      0,      0, 0},
      // axis rotations
      '{   100,    200,    300,      0,  16384,      0,      0, BY_MODEL,
             0,      0,      0, 0},
      '{   100,    200,    300,  11585,  11585,      0,      0, BY_MODEL,
             0,      0,      0, 0},
      '{ -1234,   5678,  -9012,  11585,      0,  11585,      0, BY_MODEL,
             0,      0,      0, 0},
      '{ 30000, -30000,    123,  11585,      0,      0,  11585, BY_MODEL,
             0,      0,      0, 0},
      // extreme mixed signs
      '{ 32767, -32768,  12345,  32767,  32767,  32767,  32767, BY_MODEL,
             0,      0,      0, 0},
      '{-32768,  32767,     -1, -32768,  32767, -32768,  32767, BY_MODEL,
             0,      0,      0, 0}
   };

   // divide by 2^(2*frac), truncating toward zero, then clip to 16 bits
   function automatic data_type scale_clip(input longint v, inout logic clip);
      longint s;
      s = v / (longint'(1) << (2 * QUAT_FRAC_BITS_DEF));
      if (s > longint'(SAT_MAX)) begin
         clip = 1'b1;
         return SAT_MAX;
      end
      if (s < longint'(SAT_MIN)) begin
         clip = 1'b1;
         return SAT_MIN;
      end
      return data_type'(s);
   endfunction

   // q * (0,v) * conj(q) with exact products
   function automatic rotated_vec_type rotate_vector(input rotation_req_type r);
      longint vx, vy, vz, qw, qx, qy, qz;
      longint tw, tx, ty, tz, ux, uy, uz;
      logic clip;
      rotated_vec_type o;
      vx = longint'($signed(r.vec_x));
      vy = longint'($signed(r.vec_y));
      vz = longint'($signed(r.vec_z));
      qw = longint'($signed(r.quat.w));
      qx = longint'($signed(r.quat.x));
      qy = longint'($signed(r.quat.y));
      qz = longint'($signed(r.quat.z));
      tw = -qx * vx - qy * vy - qz * vz;
      tx =  qw * vx + qy * vz - qz * vy;
      ty =  qw * vy - qx * vz + qz * vx;
      tz =  qw * vz + qx * vy - qy * vx;
      ux = -tw * qx + tx * qw - ty * qz + tz * qy;
      uy = -tw * qy + tx * qz + ty * qw - tz * qx;
      uz = -tw * qz - tx * qy + ty * qx + tz * qw;
      clip = 1'b0;
      o.rot_x = scale_clip(ux, clip);
      o.rot_y = scale_clip(uy, clip);
      o.rot_z = scale_clip(uz, clip);
      o.clipped = clip;
      return o;
   endfunction

   function automatic int idle_draw(input bit calm);
      return calm ? 0 : int'($urandom_range(0, MAX_IDLE));
   endfunction

   // component in [-lim, lim], or any 16-bit value at full range
   function automatic data_type rand_comp(input int lim);
      if (lim >= int'(SAT_MAX))
         return data_type'($urandom);
      return data_type'(int'($urandom_range(0, 2 * lim)) - lim);
   endfunction

   // mostly in-range quaternions, the rest full range to push saturation
   function automatic rotation_req_type random_rotation();
      rotation_req_type r;
      int lim;
      case ($urandom_range(0, 9)) inside
         [0:2]: begin
            lim = int'(SAT_MAX);
         end
         [3:6]: begin
            lim = 8192;
         end
         default: begin
            lim = 16384;
         end
      endcase
      r.quat.w = rand_comp(lim);
      r.quat.x = rand_comp(lim);
      r.quat.y = rand_comp(lim);
      r.quat.z = rand_comp(lim);
      if ($urandom_range(0, 19) == 0) begin
         r.vec_x = '0;
         r.vec_y = '0;
         r.vec_z = '0;
      end else begin
         r.vec_x = data_type'($urandom);
         r.vec_y = data_type'($urandom);
         r.vec_z = data_type'($urandom);
      end
      return r;
   endfunction

   // offer one request and wait for its transaction
   task automatic send_rotation(input rotation_req_type item, input rotated_vec_type owed);
      int gap;
      logic took;
      gap = idle_draw(send_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.vec_x  <= item.vec_x;
      req_if.vec_y  <= item.vec_y;
      req_if.vec_z  <= item.vec_z;
      req_if.quat_w <= item.quat.w;
      req_if.quat_x <= item.quat.x;
      req_if.quat_y <= item.quat.y;
      req_if.quat_z <= item.quat.z;
      do begin
         @(negedge clock);
         took = (req_if.ready === 1'b1);
         @(posedge clock);
      end while (!took);
      rotated_q.push_back(owed);
   endtask

   task automatic run_stimulus();
      rotation_req_type item;
      rotated_vec_type owed;
      // directed table
      for (int i = 0; i < NUM_ROWS; i++) begin
         item.vec_x  = data_type'(dir_rows[i][0]);
         item.vec_y  = data_type'(dir_rows[i][1]);
         item.vec_z  = data_type'(dir_rows[i][2]);
         item.quat.w = data_type'(dir_rows[i][3]);
         item.quat.x = data_type'(dir_rows[i][4]);
         item.quat.y = data_type'(dir_rows[i][5]);
         item.quat.z = data_type'(dir_rows[i][6]);
         if (dir_rows[i][7] == TYPED) begin
            owed.rot_x   = data_type'(dir_rows[i][8]);
            owed.rot_y   = data_type'(dir_rows[i][9]);
            owed.rot_z   = data_type'(dir_rows[i][10]);
            owed.clipped = dir_rows[i][11][0];
         end else begin
            owed = rotate_vector(item);
         end
         send_rotation(item, owed);
      end
      // random part
      for (int n = 0; n < ROT_ITEMS; n++) begin
         if ((n % STRETCH_LEN) == 0)
            send_calm = ($urandom_range(0, 3) == 0);
         item = random_rotation();
         send_rotation(item, rotate_vector(item));
      end
      req_if.valid <= 1'b0;
   endtask

   task automatic compare_field(input string name, input logic [DATA_W-1:0] exp_val,
                                input logic [DATA_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %0d, got %0d", name, $signed(exp_val),
                $signed(act_val));
         error_count++;
      end
   endtask

   // compare the result on the channel with the oldest owed vector
   task automatic check_rotation();
      rotated_vec_type owed;
      if (rotated_q.size() == 0) begin
         $error("result with nothing outstanding: rot_x %0d rot_y %0d rot_z %0d",
                rsp_if.rot_x, rsp_if.rot_y, rsp_if.rot_z);
         error_count++;
      end else begin
         owed = rotated_q.pop_front();
         compare_field("rot_x", owed.rot_x, rsp_if.rot_x);
         compare_field("rot_y", owed.rot_y, rsp_if.rot_y);
         compare_field("rot_z", owed.rot_z, rsp_if.rot_z);
         compare_field("clipped", {{(DATA_W-1){1'b0}}, owed.clipped},
                       {{(DATA_W-1){1'b0}}, rsp_if.clipped});
      end
   endtask

   // receiver: random back-pressure plus one long hold-off
   task automatic drain_rotations();
      int gap;
      logic got;
      forever begin
         gap = idle_draw(recv_calm);
         if (rsp_count == HOLD_OFF_AT && !held_off) begin
            gap = HOLD_OFF_CYCLES;
            held_off = 1'b1;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         got = 1'b0;
         while (!got) begin
            @(negedge clock);
            got = (rsp_if.valid === 1'b1);
            if (got)
               check_rotation();
            @(posedge clock);
         end
         rsp_count++;
         if ((rsp_count % STRETCH_LEN) == 0)
            recv_calm = ($urandom_range(0, 3) == 0);
      end
   endtask

   // watchdog on cycles without any transaction
   always @(negedge clock) begin
      if (reset !== 1'b1) begin
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.vec_x  <= '0;
      req_if.vec_y  <= '0;
      req_if.vec_z  <= '0;
      req_if.quat_w <= '0;
      req_if.quat_x <= '0;
      req_if.quat_y <= '0;
      req_if.quat_z <= '0;
      rsp_if.ready  <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      fork
         run_stimulus();
         drain_rotations();
      join_any
      // drain, then keep watching for stray results
      while (rotated_q.size() != 0)
         @(posedge clock);
      repeat (4 * NUM_STG) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
sv/vrq_pkg.sv
sv/vrq_if.sv
sv/vector_rotate_by_quaternion.sv
tb/sv/vector_rotate_by_quaternion_test.sv
